// ===== rtl/prd_pkg.sv =====
// shared constants and width helpers for the point to rectangle distance block
// no dependencies
package prd_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int SUM_WIDTH_MAX   = 64;

    // width rounded up to whole bytes
    function automatic int bytes_up(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

    // width of the saturated sum of squares
    function automatic int sum_width(input int coord_w);
        return (2 * coord_w + 1 > SUM_WIDTH_MAX) ? SUM_WIDTH_MAX : 2 * coord_w + 1;
    endfunction

endpackage

// ===== rtl/point_to_rectangle_distance.sv =====
// top level of the point to rectangle distance pipeline
// depends on prd_pkg, prd_excess, prd_square and prd_sqrt
//
//  channel   direction  tdata (lowest bit up)                                tuser
//  s_axis    in         point_x, point_y, center_x, center_y,               -
//                       half_width, half_height, zero pad to bytes
//  m_axis    out        distance, zero pad to bytes                          inside_res
//
//  one transfer in and one out per cycle when both sides keep up
//  the square root stages, one per result bit, set the depth
//  every stage holds its own valid, so bubbles close up under output stalls
//  synchronous active-low reset clears all valid bits
module point_to_rectangle_distance #(
    parameter int COORD_WIDTH = prd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // point_x, point_y, center_x, center_y, half_width, half_height
    input  logic [prd_pkg::bytes_up(6*COORD_WIDTH-2)-1:0] s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // distance
    output logic [prd_pkg::bytes_up(COORD_WIDTH+1)-1:0] m_axis_tdata,
    // inside_res
    output logic                                        m_axis_tuser
);
    import prd_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int SUM_W  = sum_width(W);
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int M_W    = bytes_up(W + 1);

    logic                exc_vld, exc_rdy, sq_vld, sq_rdy;
    logic [W-1:0]        ex, ey;
    logic                exc_ins, sq_ins;
    logic [SUM_W-1:0]    sum;
    logic [ROOT_W-1:0]   root;

    prd_excess #(.COORD_WIDTH(W)) u_excess (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (s_axis_tvalid),
        .o_rdy         (s_axis_tready),
        .i_point_x     (s_axis_tdata[0*W +: W]),
        .i_point_y     (s_axis_tdata[1*W +: W]),
        .i_center_x    (s_axis_tdata[2*W +: W]),
        .i_center_y    (s_axis_tdata[3*W +: W]),
        .i_half_width  (s_axis_tdata[4*W +: W-1]),
        .i_half_height (s_axis_tdata[5*W-1 +: W-1]),
        .o_vld         (exc_vld),
        .i_rdy         (exc_rdy),
        .o_ex          (ex),
        .o_ey          (ey),
        .o_inside      (exc_ins)
    );

    prd_square #(.COORD_WIDTH(W), .SUM_W(SUM_W)) u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (exc_vld),
        .o_rdy    (exc_rdy),
        .i_ex     (ex),
        .i_ey     (ey),
        .i_inside (exc_ins),
        .o_vld    (sq_vld),
        .i_rdy    (sq_rdy),
        .o_sum    (sum),
        .o_inside (sq_ins)
    );

    prd_sqrt #(.SUM_W(SUM_W), .ROOT_W(ROOT_W)) u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (sq_vld),
        .o_rdy    (sq_rdy),
        .i_sum    (sum),
        .i_inside (sq_ins),
        .o_vld    (m_axis_tvalid),
        .i_rdy    (m_axis_tready),
        .o_root   (root),
        .o_inside (m_axis_tuser)
    );

    assign m_axis_tdata = M_W'(root);

endmodule

// ===== rtl/prd_excess.sv =====
// per-axis excess of the point beyond the rectangle half sizes, three register stages
// depends on prd_pkg
module prd_excess #(
    parameter int COORD_WIDTH = prd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic        [COORD_WIDTH-2:0] i_half_width,
    input  logic        [COORD_WIDTH-2:0] i_half_height,
    output logic                          o_vld,
    input  logic                          i_rdy,
    output logic        [COORD_WIDTH-1:0] o_ex,
    output logic        [COORD_WIDTH-1:0] o_ey,
    output logic                          o_inside
);
    import prd_pkg::*;

    localparam int W = COORD_WIDTH;

    logic [2:0] r_vld;
    logic [2:0] ld;

    logic signed [W:0]   r_dx, r_dy, n_dx, n_dy;
    logic        [W-2:0] r_hw_a, r_hh_a, r_hw_b, r_hh_b;
    logic        [W-1:0] r_ax, r_ay, n_ax, n_ay;
    logic        [W-1:0] r_ex, r_ey, n_ex, n_ey;
    logic                r_ins, n_ins;
    logic signed [W:0]   neg_x, neg_y;
    logic        [W:0]   sub_x, sub_y;

    assign ld[2] = !r_vld[2] || i_rdy;
    assign ld[1] = !r_vld[1] || ld[2];
    assign ld[0] = !r_vld[0] || ld[1];
    assign o_rdy = ld[0];

    always_comb begin
        n_dx  = $signed({i_point_x[W-1], i_point_x}) - $signed({i_center_x[W-1], i_center_x});
        n_dy  = $signed({i_point_y[W-1], i_point_y}) - $signed({i_center_y[W-1], i_center_y});
        neg_x = -r_dx;
        neg_y = -r_dy;
        n_ax  = r_dx[W] ? neg_x[W-1:0] : r_dx[W-1:0];
        n_ay  = r_dy[W] ? neg_y[W-1:0] : r_dy[W-1:0];
        sub_x = {1'b0, r_ax} - {2'b00, r_hw_b};
        sub_y = {1'b0, r_ay} - {2'b00, r_hh_b};
        n_ex  = (r_ax > {1'b0, r_hw_b}) ? sub_x[W-1:0] : '0;
        n_ey  = (r_ay > {1'b0, r_hh_b}) ? sub_y[W-1:0] : '0;
        n_ins = !(r_ax > {1'b0, r_hw_b}) && !(r_ay > {1'b0, r_hh_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) r_vld[0] <= i_vld;
            if (ld[1]) r_vld[1] <= r_vld[0];
            if (ld[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_hw_a <= i_half_width;
            r_hh_a <= i_half_height;
        end
        if (ld[1]) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_hw_b <= r_hw_a;
            r_hh_b <= r_hh_a;
        end
        if (ld[2]) begin
            r_ex  <= n_ex;
            r_ey  <= n_ey;
            r_ins <= n_ins;
        end
    end

    assign o_vld    = r_vld[2];
    assign o_ex     = r_ex;
    assign o_ey     = r_ey;
    assign o_inside = r_ins;

endmodule

// ===== rtl/prd_square.sv =====
// squares of the excesses and their saturated sum, two register stages
// depends on prd_pkg
module prd_square #(
    parameter int COORD_WIDTH = prd_pkg::COORD_WIDTH_DEF,
    parameter int SUM_W       = prd_pkg::sum_width(prd_pkg::COORD_WIDTH_DEF)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    output logic                   o_rdy,
    input  logic [COORD_WIDTH-1:0] i_ex,
    input  logic [COORD_WIDTH-1:0] i_ey,
    input  logic                   i_inside,
    output logic                   o_vld,
    input  logic                   i_rdy,
    output logic [SUM_W-1:0]       o_sum,
    output logic                   o_inside
);
    import prd_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int FULL_W = 2 * W + 1;

    logic [1:0]        r_vld;
    logic [1:0]        ld;
    logic [2*W-1:0]    r_sx, r_sy;
    logic              r_ins_a, r_ins_b;
    logic [FULL_W-1:0] full;
    logic [SUM_W-1:0]  r_sum, n_sum;

    assign ld[1] = !r_vld[1] || i_rdy;
    assign ld[0] = !r_vld[0] || ld[1];
    assign o_rdy = ld[0];

    always_comb begin
        full  = {1'b0, r_sx} + {1'b0, r_sy};
        n_sum = ((full >> SUM_W) != '0) ? '1 : full[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) r_vld[0] <= i_vld;
            if (ld[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_sx    <= i_ex * i_ex;
            r_sy    <= i_ey * i_ey;
            r_ins_a <= i_inside;
        end
        if (ld[1]) begin
            r_sum   <= n_sum;
            r_ins_b <= r_ins_a;
        end
    end

    assign o_vld    = r_vld[1];
    assign o_sum    = r_sum;
    assign o_inside = r_ins_b;

endmodule

// ===== rtl/prd_sqrt.sv =====
// pipelined restoring integer square root, one result bit per register stage
// depends on prd_pkg
module prd_sqrt #(
    parameter int SUM_W = prd_pkg::sum_width(prd_pkg::COORD_WIDTH_DEF),
    parameter int ROOT_W = (SUM_W + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic              i_inside,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_inside
);
    import prd_pkg::*;

    localparam int R     = ROOT_W;
    localparam int NUM_W = 2 * R;
    localparam int REM_W = R + 2;

    logic [R-1:0]     r_vld;
    logic [R-1:0]     ld;
    logic [R-1:0]     r_ins;
    logic [NUM_W-1:0] r_num  [R];
    logic [REM_W-1:0] r_rem  [R];
    logic [R-1:0]     r_root [R];

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [REM_W-1:0] rem_in;
        logic [R-1:0]     root_in;
        logic             vld_in;
        logic             ins_in;
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic [REM_W-1:0] n_rem;
        logic [R-1:0]     n_root;

        if (k == 0) begin : g_first
            assign num_in  = NUM_W'(i_sum);
            assign rem_in  = '0;
            assign root_in = '0;
            assign vld_in  = i_vld;
            assign ins_in  = i_inside;
        end else begin : g_next
            assign num_in  = r_num[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign vld_in  = r_vld[k-1];
            assign ins_in  = r_ins[k-1];
        end

        if (k == R - 1) begin : g_last
            assign ld[k] = !r_vld[k] || i_rdy;
        end else begin : g_mid
            assign ld[k] = !r_vld[k] || ld[k+1];
        end

        always_comb begin
            t     = {rem_in, num_in[NUM_W-1 -: 2]};
            trial = (REM_W + 2)'({root_in, 2'b01});
            diff  = t - trial;
            if (t >= trial) begin
                n_rem  = diff[REM_W-1:0];
                n_root = {root_in[R-2:0], 1'b1};
            end else begin
                n_rem  = t[REM_W-1:0];
                n_root = {root_in[R-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (ld[k]) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (ld[k]) begin
                r_num[k]  <= {num_in[NUM_W-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_ins[k]  <= ins_in;
            end
        end
    end

    assign o_rdy    = ld[0];
    assign o_vld    = r_vld[R-1];
    assign o_root   = r_root[R-1];
    assign o_inside = r_ins[R-1];

endmodule

// ===== rtl/prd_checker.sv =====
// port-level checks on the point to rectangle distance block, bound to the top level
// depends on prd_pkg and point_to_rectangle_distance
module prd_checker #(
    parameter int COORD_WIDTH = prd_pkg::COORD_WIDTH_DEF
) (
    input logic                                        i_clk,
    input logic                                        i_rst_n,
    input logic                                        m_axis_tvalid,
    input logic                                        m_axis_tready,
    input logic [prd_pkg::bytes_up(COORD_WIDTH+1)-1:0] m_axis_tdata,
    input logic                                        m_axis_tuser
);
    import prd_pkg::*;

    localparam int DIST_W = COORD_WIDTH + 1;

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled transfer keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // inside or on the border means zero distance
    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("inside with non-zero distance");

    // outside means at least one lsb of distance
    a_outside_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
        else $error("outside with zero distance");

    // pad bits above the distance stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> DIST_W) == '0)
        else $error("pad bits set");

endmodule

bind point_to_rectangle_distance prd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_prd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/testbench.sv =====
// self-checking testbench for point_to_rectangle_distance
// depends on prd_pkg and the rtl top level; predicts every result internally
`timescale 1ns / 100ps

module testbench;

    localparam int COORD_W      = prd_pkg::COORD_WIDTH_DEF;
    localparam int IN_W         = prd_pkg::bytes_up(6*COORD_W-2);
    localparam int OUT_W        = prd_pkg::bytes_up(COORD_W+1);
    localparam int RANDOM_ITEMS = 590;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [14:0] half_height;
        logic [14:0] half_width;
        logic [15:0] center_y;
        logic [15:0] center_x;
        logic [15:0] point_y;
        logic [15:0] point_x;
    } t_query;

    typedef struct packed {
        logic [16:0] distance;
        logic        inside_res;
    } t_dist_result;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY} t_rx_mode;

    localparam int QUERY_W = $bits(t_query);

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;

    t_dist_result      pending_distances[$];
    int                mismatch_count = 0;
    int                inside_seen    = 0;
    int                outside_seen   = 0;
    int                queries_sent   = 0;
    int                cycle_count    = 0;

    bit                tx_gappy   = 1'b0;
    int                burst_left = 0;
    t_rx_mode          rx_mode    = RX_OPEN;
    int                hold_req   = 0;
    int                hold_cnt   = 0;
    int                rx_phase   = 0;
    logic [31:0]       rx_pattern = '1;

    point_to_rectangle_distance #(.COORD_WIDTH(COORD_W)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // point_x, point_y, center_x, center_y, half_width, half_height
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // distance
        .m_axis_tdata  (m_axis_tdata),
        // inside_res
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned axis_excess(input logic [15:0] p, input logic [15:0] c,
                                                    input logic [14:0] h);
        longint d;
        d = longint'($signed(p)) - longint'($signed(c));
        if (d < 0)
            d = -d;
        return (d > longint'(h)) ? longint'(d - longint'(h)) : 0;
    endfunction

    function automatic t_dist_result predict_distance(input t_query q);
        longint unsigned ex, ey, sum_sq, root, trial;
        t_dist_result    r;
        ex     = axis_excess(q.point_x, q.center_x, q.half_width);
        ey     = axis_excess(q.point_y, q.center_y, q.half_height);
        sum_sq = ex * ex + ey * ey;
        root   = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum_sq)
                root = trial;
        end
        r.inside_res = (ex == 0) && (ey == 0);
        r.distance   = r.inside_res ? 17'd0 : root[16:0];
        return r;
    endfunction

    function automatic t_query make_query(input int px, input int py, input int cx, input int cy,
                                          input int hw, input int hh);
        t_query q;
        q.point_x     = px[15:0];
        q.point_y     = py[15:0];
        q.center_x    = cx[15:0];
        q.center_y    = cy[15:0];
        q.half_width  = hw[14:0];
        q.half_height = hh[14:0];
        return q;
    endfunction

    function automatic t_query random_query();
        t_query q;
        int     kind, span, off;
        q.point_x     = 16'($urandom);
        q.point_y     = 16'($urandom);
        q.center_x    = 16'($urandom);
        q.center_y    = 16'($urandom);
        q.half_width  = 15'($urandom);
        q.half_height = 15'($urandom);
        kind = $urandom_range(0, 9);
        if (kind >= 4 && kind <= 6) begin
            // points scattered around a modest box
            q.half_width  = 15'($urandom_range(0, 2047));
            q.half_height = 15'($urandom_range(0, 2047));
            span = int'(q.half_width) + 64;
            off  = int'($urandom_range(0, 2*span)) - span;
            q.point_x = q.center_x + off[15:0];
            span = int'(q.half_height) + 64;
            off  = int'($urandom_range(0, 2*span)) - span;
            q.point_y = q.center_y + off[15:0];
        end else if (kind == 7) begin
            // exactly on a vertical edge
            off = $urandom_range(0, 1) ? int'(q.half_width) : -int'(q.half_width);
            q.point_x = q.center_x + off[15:0];
            off = int'($urandom_range(0, 2*q.half_height)) - int'(q.half_height);
            q.point_y = q.center_y + off[15:0];
        end else if (kind == 8) begin
            // degenerate box, plain point distance
            q.half_width  = '0;
            q.half_height = '0;
            off = int'($urandom_range(0, 8191)) - 4096;
            q.point_x = q.center_x + off[15:0];
            off = int'($urandom_range(0, 8191)) - 4096;
            q.point_y = q.center_y + off[15:0];
        end
        return q;
    endfunction

    task automatic send_query(input t_query q);
        int gap;
        if (tx_gappy) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(q);
        do @(posedge i_clk); while (!s_axis_tready);
        queries_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_corner_cases();
        t_query corners[20];
        tx_gappy = 1'b0;
        rx_mode  = RX_OPEN;
        corners = '{
            make_query(0, 0, 0, 0, 0, 0),
            make_query(100, -50, 0, 0, 256, 256),
            make_query(256, 0, 0, 0, 256, 256),
            make_query(-256, -256, 0, 0, 256, 256),
            make_query(257, 0, 0, 0, 256, 256),
            make_query(0, -257, 0, 0, 256, 256),
            make_query(768, 1024, 0, 0, 0, 0),
            make_query(-32768, -32768, 32767, 32767, 0, 0),
            make_query(32767, 32767, -32768, -32768, 0, 0),
            make_query(32767, -32768, -32768, 32767, 32767, 32767),
            make_query(32767, 32767, 0, 0, 32767, 32767),
            make_query(-32768, 0, 0, 0, 32767, 0),
            make_query(-1, -1, -1, -1, 32767, 32767),
            make_query('h5555, 'haaaa, 'haaaa, 'h5555, 'h2aaa, 'h5555),
            make_query('haaaa, 'h5555, 'h5555, 'haaaa, 'h5555, 'h2aaa),
            make_query(1000, 1000, -1000, -1000, 500, 500),
            make_query(5000, 0, 0, 0, 1000, 32767),
            make_query(0, -5000, 0, 0, 32767, 1000),
            make_query(-5000, 0, 0, 0, 1000, 0),
            make_query(1, 0, 0, 0, 0, 0)
        };
        foreach (corners[i])
            send_query(corners[i]);
        stop_sending();
    endtask

    task automatic test_back_to_back();
        tx_gappy = 1'b0;
        rx_mode  = RX_OPEN;
        repeat (60)
            send_query(random_query());
        stop_sending();
    endtask

    task automatic test_output_backpressure();
        tx_gappy = 1'b0;
        rx_mode  = RX_OPEN;
        hold_req = HOLD_CYCLES;
        repeat (80)
            send_query(random_query());
        stop_sending();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                tx_gappy = ($urandom_range(0, 3) != 0);
                rx_mode  = t_rx_mode'($urandom_range(0, 2));
            end
            send_query(random_query());
        end
        stop_sending();
    endtask

    task automatic drain_pipeline();
        rx_mode = RX_OPEN;
        while (pending_distances.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver stall pattern plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (rx_mode == RX_OPEN) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_phase == 0)
                rx_pattern = (rx_mode == RX_LIGHT) ? ($urandom | $urandom)
                                                   : ($urandom & $urandom);
            m_axis_tready <= rx_pattern[rx_phase];
            rx_phase = (rx_phase + 1) % 32;
        end
    end

    // result check first, then queue the prediction for an accepted query
    always @(posedge i_clk) begin
        t_dist_result got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.distance   = m_axis_tdata[16:0];
                got.inside_res = m_axis_tuser;
                if (got.inside_res === 1'b1)
                    inside_seen++;
                else
                    outside_seen++;
                if (pending_distances.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transfer: distance %0d inside %0b",
                                 got.distance, got.inside_res);
                end else begin
                    want = pending_distances.pop_front();
                    if (got.distance !== want.distance || got.inside_res !== want.inside_res) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: distance exp %0d got %0d, inside exp %0b got %0b",
                                     want.distance, got.distance,
                                     want.inside_res, got.inside_res);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_distances.insert(pending_distances.size(),
                    predict_distance(t_query'(s_axis_tdata[QUERY_W-1:0])));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cases();
        test_back_to_back();
        test_output_backpressure();
        test_random_traffic();
        drain_pipeline();
        if (pending_distances.size() != 0) begin
            $display("%0d results never arrived", pending_distances.size());
            mismatch_count += pending_distances.size();
        end
        $display("queries sent %0d, results inside %0d, outside %0d", queries_sent,
                 inside_seen, outside_seen);
        $display("traffic: back-to-back, bursty sender, patterned stalls, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
